FILE: hdl/ftff_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the force/torque frame filter.
package ftff_pkg;

   localparam int NUM_CH     = 12;
   localparam int CH_W       = 4;
   localparam int ID_W       = 11;
   localparam int WORD_W     = 16;
   localparam int COEFF_W    = 16;
   localparam int CAL_W      = 8;
   localparam int CSR_DATA_W = 16;
   localparam int SMP_W      = 34;
   localparam int OUT_W      = 33;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_W     = SMP_W + 1;
   localparam int PROD_W     = DIFF_W + COEFF_W + 1;
   localparam int ACC_W      = PROD_W + 1;
   localparam int SHIFT_W    = ACC_W - COEFF_W;

   localparam logic [WORD_W-1:0]  FORCE_OFFSET  = 16'd30000;
   localparam logic [WORD_W-1:0]  TORQUE_OFFSET = 16'd25000;
   localparam logic [COEFF_W-1:0] COEFF_RESET   = 16'd31969;
   localparam logic [CAL_W-1:0]   CAL_RESET     = 8'd100;

   typedef logic signed [SMP_W-1:0] store_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef enum logic [1:0] {
      REG_ID_RIGHT,
      REG_ID_LEFT,
      REG_FILTER_COEFF,
      REG_CAL_GROUPS
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_FILTER,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      MODE_CAL,
      MODE_FINAL,
      MODE_EMIT
   } mode_type;

   function automatic out_type sat_out(store_type v);
      out_type r;
      if (v[SMP_W-1] != v[OUT_W-1]) begin
         r = v[SMP_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   function automatic store_type sat_store(logic signed [SHIFT_W-1:0] v);
      store_type r;
      if ((&v[SHIFT_W-1:SMP_W-1]) || !(|v[SHIFT_W-1:SMP_W-1])) begin
         r = v[SMP_W-1:0];
      end else begin
         r = v[SHIFT_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: hdl/ftff_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame input, result output and register writes.
interface ftff_req_if
   import ftff_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   can_id;
   logic [WORD_W-1:0] word_a;
   logic [WORD_W-1:0] word_b;
   logic [WORD_W-1:0] word_c;

   modport source (output valid, can_id, word_a, word_b, word_c, input ready);
   modport sink   (input valid, can_id, word_a, word_b, word_c, output ready);
endinterface

interface ftff_rsp_if
   import ftff_pkg::*;
();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] channel;
   out_type         smoothed;
   out_type         sample;
   logic            last;

   modport source (output valid, channel, smoothed, sample, last, input ready);
   modport sink   (input valid, channel, smoothed, sample, last, output ready);
endinterface

interface ftff_csr_if
   import ftff_pkg::*;
();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/ft_sensor_frame_filter_core.sv
`timescale 1ns / 1ps
// Force/torque frame filter: bias correction and moving-average smoothing of twelve channels.
//
// Frames are taken one at a time. A frame that does not close a four-frame group is
// accepted and, when its identifier matches the expected slot, then writes its three
// corrected samples (one bias-store read and one sample-store write per cycle). The frame
// that closes a group, after its own samples when its identifier matches, then runs the
// twelve channels through a single multiplier, one channel per cycle while results do
// not wait on rsp_ch.ready, plus pipeline fill and drain. After calibration each group
// yields twelve words on rsp_ch, channel 0 to 11, the last flagged. All stores sit in
// small synchronous memories; per-entry valid bits stand in for their zero reset, so
// there is no clearing pass after reset.
module ft_sensor_frame_filter_core
   import ftff_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ftff_req_if.sink  req_ch,
   ftff_rsp_if.source rsp_ch,
   ftff_csr_if.sink  csr_ch
);

   logic [ID_W-1:0]    id_right_ff;
   logic [ID_W-1:0]    id_left_ff;
   logic [COEFF_W-1:0] coeff_ff;
   logic [CAL_W-1:0]   cal_groups_ff;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [1:0]         slot_ff, slot_in;
   logic [1:0]         base_ff, base_in;
   logic [CAL_W-1:0]   groups_ff, groups_in;
   logic               calibrating_ff, calibrating_in;
   logic [1:0]         k_ff, k_in;
   logic [CH_W-1:0]    cnt_ff, cnt_in;

   logic [WORD_W-1:0]  words_ff [3];

   store_type          sample_mem [NUM_CH];
   store_type          smooth_mem [NUM_CH];
   out_type            bias_mem   [NUM_CH];
   logic [NUM_CH-1:0]  sample_vld_ff;
   logic [NUM_CH-1:0]  smooth_vld_ff;
   logic [NUM_CH-1:0]  bias_vld_ff;

   out_type            bias_rd_ff;
   logic               bias_rv_ff;
   store_type          smp_rd_ff;
   logic               smp_rv_ff;
   store_type          smo_rd_ff;
   logic               smo_rv_ff;

   logic               sw_vld_ff;
   logic [CH_W-1:0]    sw_ch_ff;
   logic [1:0]         sw_k_ff;

   logic               s1_vld_ff, s1_vld_in;
   logic [CH_W-1:0]    s1_ch_ff;
   logic               s2_vld_ff, s2_vld_in;
   logic [CH_W-1:0]    s2_ch_ff;
   logic signed [PROD_W-1:0] prod_ff;
   store_type          x2_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]    rsp_chan_ff;
   out_type            rsp_smoothed_ff;
   out_type            rsp_sample_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic [ID_W-1:0]    expect_id;
   logic               match;
   logic               adv;
   logic               bias_rd_en;
   logic               filt_rd_en;
   logic               finish;
   logic               clear_vld;
   logic [CAL_W-1:0]   grp_next;
   logic [CH_W-1:0]    base_ch;
   logic [CH_W-1:0]    rd_ch;

   logic [WORD_W-1:0]  sw_word;
   logic [WORD_W-1:0]  sw_off;
   logic signed [WORD_W:0] sw_xs;
   store_type          sw_xq;
   out_type            sw_bias;
   store_type          sample_wdata;

   store_type          smo_val;
   store_type          smp_val;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc;
   store_type          new_smooth;
   logic               s2_fire;
   logic               load;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.channel  = rsp_chan_ff;
   assign rsp_ch.smoothed = rsp_smoothed_ff;
   assign rsp_ch.sample   = rsp_sample_ff;
   assign rsp_ch.last     = rsp_last_ff;

   assign adv      = !(rsp_valid_ff && !rsp_ch.ready);
   assign grp_next = groups_ff + 1'b1;
   assign base_ch  = {1'b0, base_ff, 1'b0} + {2'b00, base_ff};
   assign rd_ch    = base_ch + {2'b00, k_ff};

   always_comb begin
      unique case (slot_ff)
         2'd0:    expect_id = id_right_ff;
         2'd1:    expect_id = id_right_ff + 1'b1;
         2'd2:    expect_id = id_left_ff;
         default: expect_id = id_left_ff + 1'b1;
      endcase
   end

   assign match = (req_ch.can_id == expect_id);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      slot_in        = slot_ff;
      base_in        = base_ff;
      groups_in      = groups_ff;
      calibrating_in = calibrating_ff;
      k_in           = k_ff;
      cnt_in         = cnt_ff;
      accept         = 1'b0;
      bias_rd_en     = 1'b0;
      filt_rd_en     = 1'b0;
      finish         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               accept  = 1'b1;
               slot_in = slot_ff + 1'b1;
               base_in = slot_ff;
               k_in    = '0;
               cnt_in  = '0;
               if (slot_ff == 2'd3) begin
                  if (!calibrating_ff) begin
                     mode_in = MODE_EMIT;
                  end else if (grp_next == cal_groups_ff) begin
                     mode_in   = MODE_FINAL;
                     groups_in = '0;
                  end else begin
                     mode_in   = MODE_CAL;
                     groups_in = grp_next;
                  end
               end
               if (match) begin
                  state_in = ST_SAMPLE;
               end else if (slot_ff == 2'd3) begin
                  state_in = ST_FILTER;
               end
            end
         end
         ST_SAMPLE: begin
            bias_rd_en = 1'b1;
            k_in       = k_ff + 1'b1;
            if (k_ff == 2'd2) begin
               k_in     = '0;
               state_in = (base_ff == 2'd3) ? ST_FILTER : ST_IDLE;
            end
         end
         ST_FILTER: begin
            if (adv) begin
               filt_rd_en = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               if (cnt_ff == CH_W'(NUM_CH - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               if (mode_ff == MODE_FINAL) begin
                  calibrating_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign clear_vld = finish && (mode_ff == MODE_FINAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         mode_ff        <= MODE_CAL;
         slot_ff        <= '0;
         base_ff        <= '0;
         groups_ff      <= '0;
         calibrating_ff <= 1'b1;
         k_ff           <= '0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         slot_ff        <= slot_in;
         base_ff        <= base_in;
         groups_ff      <= groups_in;
         calibrating_ff <= calibrating_in;
         k_ff           <= k_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_right_ff   <= '0;
         id_left_ff    <= '0;
         coeff_ff      <= COEFF_RESET;
         cal_groups_ff <= CAL_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_ID_RIGHT:     id_right_ff   <= csr_ch.data[ID_W-1:0];
            REG_ID_LEFT:      id_left_ff    <= csr_ch.data[ID_W-1:0];
            REG_FILTER_COEFF: coeff_ff      <= csr_ch.data[COEFF_W-1:0];
            REG_CAL_GROUPS:   cal_groups_ff <= csr_ch.data[CAL_W-1:0];
            default:          id_right_ff   <= id_right_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         words_ff[0] <= req_ch.word_a;
         words_ff[1] <= req_ch.word_b;
         words_ff[2] <= req_ch.word_c;
      end
   end

   // sample = ((word - offset) << FRAC_BITS) - bias; fits 34 bits without saturation
   assign sw_word      = words_ff[sw_k_ff];
   assign sw_off       = base_ff[0] ? TORQUE_OFFSET : FORCE_OFFSET;
   assign sw_xs        = $signed({1'b0, sw_word}) - $signed({1'b0, sw_off});
   assign sw_xq        = {{(SMP_W-WORD_W-1-FRAC_BITS){sw_xs[WORD_W]}}, sw_xs,
                          {FRAC_BITS{1'b0}}};
   assign sw_bias      = bias_rv_ff ? bias_rd_ff : '0;
   assign sample_wdata = sw_xq - {sw_bias[OUT_W-1], sw_bias};

   // smoothed = (alpha*(s - x) + x*65536) / 65536, rounded half up
   assign smo_val = smo_rv_ff ? smo_rd_ff : '0;
   assign smp_val = smp_rv_ff ? smp_rd_ff : '0;
   assign diff    = {smo_val[SMP_W-1], smo_val} - {smp_val[SMP_W-1], smp_val};
   assign prod_in = PROD_W'($signed({1'b0, coeff_ff})) * PROD_W'(diff);
   assign acc     = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}
                  + {{(ACC_W-SMP_W-COEFF_W){x2_ff[SMP_W-1]}}, x2_ff, {COEFF_W{1'b0}}}
                  + (ACC_W'(1) << (COEFF_W - 1));
   assign new_smooth = sat_store(acc[ACC_W-1:COEFF_W]);

   assign s2_fire = s2_vld_ff && adv;
   assign load    = s2_fire && (mode_ff == MODE_EMIT);

   always_ff @(posedge clock) begin
      if (sw_vld_ff) begin
         sample_mem[sw_ch_ff] <= sample_wdata;
      end
      if (filt_rd_en) begin
         smp_rd_ff <= sample_mem[cnt_ff];
         smo_rd_ff <= smooth_mem[cnt_ff];
      end
      if (s2_fire) begin
         smooth_mem[s2_ch_ff] <= new_smooth;
      end
      if (s2_fire && (mode_ff == MODE_FINAL)) begin
         bias_mem[s2_ch_ff] <= sat_out(new_smooth);
      end
      if (bias_rd_en) begin
         bias_rd_ff <= bias_mem[rd_ch];
      end
   end

   always_ff @(posedge clock) begin
      if (filt_rd_en) begin
         smp_rv_ff <= sample_vld_ff[cnt_ff];
         smo_rv_ff <= smooth_vld_ff[cnt_ff];
      end
      if (bias_rd_en) begin
         bias_rv_ff <= bias_vld_ff[rd_ch];
      end
      sw_ch_ff <= rd_ch;
      sw_k_ff  <= k_ff;
      if (adv) begin
         s1_ch_ff <= cnt_ff;
         s2_ch_ff <= s1_ch_ff;
         prod_ff  <= prod_in;
         x2_ff    <= smp_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_vld_ff <= '0;
         smooth_vld_ff <= '0;
         bias_vld_ff   <= '0;
      end else if (clear_vld) begin
         sample_vld_ff <= '0;
         smooth_vld_ff <= '0;
      end else begin
         if (sw_vld_ff) begin
            sample_vld_ff[sw_ch_ff] <= 1'b1;
         end
         if (s2_fire) begin
            smooth_vld_ff[s2_ch_ff] <= 1'b1;
         end
         if (s2_fire && (mode_ff == MODE_FINAL)) begin
            bias_vld_ff[s2_ch_ff] <= 1'b1;
         end
      end
   end

   assign s1_vld_in    = adv ? filt_rd_en : s1_vld_ff;
   assign s2_vld_in    = adv ? s1_vld_ff : s2_vld_ff;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sw_vld_ff    <= bias_rd_en;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_chan_ff     <= s2_ch_ff;
         rsp_smoothed_ff <= sat_out(new_smooth);
         rsp_sample_ff   <= sat_out(x2_ff);
         rsp_last_ff     <= (s2_ch_ff == CH_W'(NUM_CH - 1));
      end
   end

endmodule

FILE: tb/ft_sensor_frame_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the force/torque frame filter core with a built-in predictor.
module ft_sensor_frame_filter_core_tb
   import ftff_pkg::*;
();

   typedef struct {
      logic [ID_W-1:0]   can_id;
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic [WORD_W-1:0] word_c;
   } frame_type;

   typedef struct {
      logic [CH_W-1:0] channel;
      out_type         smoothed;
      out_type         sample;
      logic            last;
   } channel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ftff_req_if req_ch ();
   ftff_rsp_if rsp_ch ();
   ftff_csr_if csr_ch ();

   ft_sensor_frame_filter_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // register copies
   logic [ID_W-1:0]    cfg_id_right = '0;
   logic [ID_W-1:0]    cfg_id_left  = '0;
   logic [COEFF_W-1:0] cfg_coeff    = COEFF_RESET;
   logic [CAL_W-1:0]   cfg_cal      = CAL_RESET;

   // filter state
   store_type        sample_mem [NUM_CH];
   store_type        smooth_mem [NUM_CH];
   out_type          bias_mem   [NUM_CH];
   logic [1:0]       frame_slot  = '0;
   logic [CAL_W-1:0] groups_seen = '0;
   bit               calibrating = 1'b1;

   frame_type          can_frames [$];
   channel_result_type due_channels [$];
   channel_result_type head_result;

   logic [1:0] next_slot   = '0;
   bit         frame_taken = 1'b0;
   bit         steady_flow = 1'b0;
   int         send_gap    = 0;
   int         recv_gap    = 0;
   int         rsp_holdoff = 0;
   int         fail_count  = 0;
   frame_type  drive_frame;

   function automatic longint clamp_to(longint v, int bits);
      longint top;
      top = (longint'(1) <<< (bits - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   function automatic logic [ID_W-1:0] slot_id(logic [1:0] s);
      case (s)
         2'd0: return cfg_id_right;
         2'd1: return cfg_id_right + 1'b1;
         2'd2: return cfg_id_left;
         default: return cfg_id_left + 1'b1;
      endcase
   endfunction

   function automatic void apply_register(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_ID_RIGHT:     cfg_id_right = d[ID_W-1:0];
         REG_ID_LEFT:      cfg_id_left  = d[ID_W-1:0];
         REG_FILTER_COEFF: cfg_coeff    = d[COEFF_W-1:0];
         REG_CAL_GROUPS:   cfg_cal      = d[CAL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void filter_frame(frame_type f);
      logic [WORD_W-1:0] words [3];
      longint offs;
      longint acc;
      longint diff;
      int base;
      words[0] = f.word_a;
      words[1] = f.word_b;
      words[2] = f.word_c;
      offs = frame_slot[0] ? longint'(TORQUE_OFFSET) : longint'(FORCE_OFFSET);
      base = int'(frame_slot) * 3;
      if (f.can_id == slot_id(frame_slot)) begin
         for (int i = 0; i < 3; i++) begin
            diff = (longint'(words[i]) - offs) <<< FRAC_BITS;
            sample_mem[base + i] =
               store_type'(clamp_to(diff - longint'(bias_mem[base + i]), SMP_W));
         end
      end
      if (frame_slot != 2'd3) begin
         frame_slot++;
         return;
      end
      frame_slot = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         acc = longint'(cfg_coeff) * longint'(smooth_mem[i])
             + (longint'(65536) - longint'(cfg_coeff)) * longint'(sample_mem[i]) + 32768;
         smooth_mem[i] = store_type'(clamp_to(acc >>> FRAC_BITS, SMP_W));
      end
      if (calibrating) begin
         groups_seen++;
         if (groups_seen == cfg_cal) begin
            for (int i = 0; i < NUM_CH; i++) begin
               bias_mem[i]   = out_type'(clamp_to(smooth_mem[i], OUT_W));
               smooth_mem[i] = '0;
               sample_mem[i] = '0;
            end
            groups_seen = '0;
            calibrating = 1'b0;
         end
         return;
      end
      for (int i = 0; i < NUM_CH; i++) begin
         due_channels.push_back('{channel:  CH_W'(i),
                                  smoothed: out_type'(clamp_to(smooth_mem[i], OUT_W)),
                                  sample:   out_type'(clamp_to(sample_mem[i], OUT_W)),
                                  last:     (i == NUM_CH - 1)});
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [WORD_W-1:0] pick_word(bit torque);
      int r;
      logic [WORD_W-1:0] mid;
      mid = torque ? TORQUE_OFFSET : FORCE_OFFSET;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return '1;
         2: return mid + WORD_W'($urandom_range(0, 4)) - 16'd2;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic void add_frame(bit hit, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                     logic [WORD_W-1:0] c);
      frame_type f;
      logic [ID_W-1:0] want;
      want = slot_id(next_slot);
      f.can_id = hit ? want : want + ID_W'($urandom_range(1, 2047));
      f.word_a = a;
      f.word_b = b;
      f.word_c = c;
      can_frames.push_back(f);
      next_slot++;
   endfunction

   function automatic void add_group(int miss_pct);
      bit torque;
      for (int k = 0; k < 4; k++) begin
         torque = (k % 2 == 1);
         add_frame($urandom_range(0, 99) >= miss_pct, pick_word(torque), pick_word(torque),
                   pick_word(torque));
      end
   endfunction

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      apply_register(idx, d);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic settle_block();
      do @(posedge clock);
      while (can_frames.size() != 0 || req_ch.valid || due_channels.size() != 0);
      repeat (64) @(posedge clock);
   endtask

   // frame driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || frame_taken) begin
         if (send_gap > 0) begin
            req_ch.valid <= 1'b0;
            send_gap--;
         end else if (can_frames.size() != 0) begin
            drive_frame = can_frames.pop_front();
            req_ch.can_id <= drive_frame.can_id;
            req_ch.word_a <= drive_frame.word_a;
            req_ch.word_b <= drive_frame.word_b;
            req_ch.word_c <= drive_frame.word_c;
            req_ch.valid  <= 1'b1;
            send_gap = steady_flow ? 0 : pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         frame_taken <= 1'b0;
      end else begin
         frame_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            filter_frame('{can_id: req_ch.can_id, word_a: req_ch.word_a,
                           word_b: req_ch.word_b, word_c: req_ch.word_c});
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_holdoff > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_holdoff--;
      end else if (recv_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_gap--;
      end else begin
         rsp_ch.ready <= 1'b1;
         recv_gap = steady_flow ? 0 : pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_channels.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected word, expected none, got ch %0d sm %0d smp %0d last %0b",
                     $time, rsp_ch.channel, rsp_ch.smoothed, rsp_ch.sample, rsp_ch.last);
         end else begin
            head_result = due_channels.pop_front();
            if (rsp_ch.channel !== head_result.channel || rsp_ch.smoothed !== head_result.smoothed
                || rsp_ch.sample !== head_result.sample || rsp_ch.last !== head_result.last) begin
               fail_count++;
               $display("%0t ns: word mismatch, expected ch %0d smoothed %0d sample %0d last %0b",
                        $time, head_result.channel, head_result.smoothed, head_result.sample,
                        head_result.last);
               $display("%0t ns:      got      ch %0d smoothed %0d sample %0d last %0b",
                        $time, rsp_ch.channel, rsp_ch.smoothed, rsp_ch.sample, rsp_ch.last);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_CH; i++) begin
         sample_mem[i] = '0;
         smooth_mem[i] = '0;
         bias_mem[i]   = '0;
      end
      req_ch.valid  = 1'b0;
      req_ch.can_id = '0;
      req_ch.word_a = '0;
      req_ch.word_b = '0;
      req_ch.word_c = '0;
      rsp_ch.ready  = 1'b0;
      csr_ch.valid  = 1'b0;
      csr_ch.index  = REG_ID_RIGHT;
      csr_ch.data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // upper data bits must be dropped
      write_register(REG_ID_RIGHT, 16'hFFFF);
      write_register(REG_ID_LEFT, 16'h0400);
      write_register(REG_FILTER_COEFF, 16'hFFFF);
      write_register(REG_CAL_GROUPS, 16'd5);

      add_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_frame(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
      add_frame(1'b0, 16'h1234, 16'h5678, 16'h9ABC);
      add_frame(1'b1, FORCE_OFFSET, FORCE_OFFSET, FORCE_OFFSET);
      add_frame(1'b1, TORQUE_OFFSET, TORQUE_OFFSET, TORQUE_OFFSET);
      add_frame(1'b1, 16'hAAAA, 16'h5555, 16'hAAAA);
      add_frame(1'b1, 16'h5555, 16'hAAAA, 16'h5555);
      add_frame(1'b0, 16'h8000, 16'h7FFF, 16'h8000);
      add_frame(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF);
      add_frame(1'b0, 16'h0001, 16'hFFFE, 16'h0001);
      add_frame(1'b0, 16'hFFFE, 16'h0001, 16'hFFFE);
      settle_block();

      // one more random group before calibration closes
      write_register(REG_FILTER_COEFF, 16'd49152);
      add_group(10);
      settle_block();

      // close calibration on extreme words so the bias lands at its extremes
      write_register(REG_FILTER_COEFF, 16'd0);
      add_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);
      add_frame(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_frame(1'b1, 16'h0000, 16'h0000, 16'h0000);

      for (int phase = 0; phase < 6; phase++) begin
         settle_block();
         case (phase)
            0: begin
               write_register(REG_FILTER_COEFF, 16'hFFFF);
               write_register(REG_ID_RIGHT, CSR_DATA_W'($urandom));
               write_register(REG_ID_LEFT, CSR_DATA_W'($urandom));
            end
            1: begin
               write_register(REG_FILTER_COEFF, 16'd1);
               write_register(REG_CAL_GROUPS, 16'd255);
            end
            2: begin
               write_register(REG_FILTER_COEFF, CSR_DATA_W'($urandom));
               write_register(REG_ID_RIGHT, 16'h0000);
               write_register(REG_ID_LEFT, 16'h07FF);
            end
            3: begin
               write_register(REG_FILTER_COEFF, 16'h8000);
               write_register(REG_CAL_GROUPS, 16'd1);
            end
            4: begin
               write_register(REG_FILTER_COEFF, CSR_DATA_W'($urandom));
               write_register(REG_ID_RIGHT, CSR_DATA_W'($urandom));
               write_register(REG_ID_LEFT, CSR_DATA_W'($urandom));
            end
            default: begin
               // same identifier on both sides
               drive_frame.can_id = ID_W'($urandom);
               write_register(REG_FILTER_COEFF, 16'd0);
               write_register(REG_ID_RIGHT, CSR_DATA_W'(drive_frame.can_id));
               write_register(REG_ID_LEFT, CSR_DATA_W'(drive_frame.can_id));
            end
         endcase
         steady_flow = (phase == 2);
         if (phase == 0) rsp_holdoff = 300;
         repeat (9) add_group(15);
      end

      settle_block();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
